// ===== sv/ccg_pkg.sv =====
package ccg_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int POLY_DEPTH = MAX_DEGREE + 1;
    localparam int AW         = $clog2(POLY_DEPTH);
    localparam int DEG_W      = 6;
    localparam int COEF_W     = 64;
    localparam int NUM_RAMS   = 3;

    typedef logic [1:0] role_t;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             second_kind;
        logic             absolute_values;
    } req_t;

    typedef struct packed {
        logic [DEG_W-1:0]         power_index;
        logic signed [COEF_W-1:0] coefficient;
        logic                     last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_STEP,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic [1:0] {
        ALU_RECUR,
        ALU_PASS,
        ALU_NEG
    } alu_op_t;

endpackage

// ===== sv/ccg_ram.sv =====
module ccg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ccg_alu.sv =====
module ccg_alu import ccg_pkg::*; (
    input  alu_op_t           op,
    input  logic [COEF_W-1:0] a,
    input  logic [COEF_W-1:0] b,
    output logic [COEF_W-1:0] y
);

    logic [COEF_W-1:0] lhs;
    logic [COEF_W-1:0] rhs;

    // one subtractor: 2a - b, a - 0, or 0 - a
    always_comb
    begin
        case (op)
            ALU_RECUR:
            begin
                lhs = {a[COEF_W-2:0], 1'b0};
                rhs = b;
            end
            ALU_PASS:
            begin
                lhs = a;
                rhs = '0;
            end
            ALU_NEG:
            begin
                lhs = '0;
                rhs = a;
            end
            default:
            begin
                lhs = a;
                rhs = '0;
            end
        endcase
        y = lhs - rhs;
    end

endmodule

// ===== sv/chebyshev_coefficient_generator.sv =====
// Builds the integer coefficients of the Chebyshev polynomial T_n or U_n for a
// request of degree n (0 is taken as 1, anything above MAX_DEGREE as MAX_DEGREE)
// and returns n+1 results, power 0 first, with last set on power n; magnitudes
// are returned when absolute_values is set. The block holds req_stall high from
// the accepted request until the last result is loaded into the output register,
// so it works on one request at a time. Each recurrence pass k steps j from 0
// to k+1 through the one shared subtractor and the single read port of each of
// the three coefficient RAMs, then rotates the RAM roles; each result is a RAM
// read, then a load into the output register. No clearing pass is needed:
// entries outside the degree of a stored polynomial are forced to zero by index.
module chebyshev_coefficient_generator import ccg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    role_t  old_role_reg, old_role_next;
    role_t  cur_role_reg, cur_role_next;
    role_t  nxt_role_reg, nxt_role_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] jd_reg, jd_next;
    logic pipe_valid_reg, pipe_valid_next;
    logic cur_zero_reg, cur_zero_next;
    logic old_zero_reg, old_zero_next;
    logic second_reg, second_next;
    logic magn_reg, magn_next;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;

    logic              ram_we    [NUM_RAMS];
    logic [AW-1:0]     ram_waddr [NUM_RAMS];
    logic [COEF_W-1:0] ram_wdata [NUM_RAMS];
    logic              ram_re    [NUM_RAMS];
    logic [AW-1:0]     ram_raddr [NUM_RAMS];
    logic [COEF_W-1:0] ram_rdata [NUM_RAMS];

    alu_op_t           alu_op;
    logic [COEF_W-1:0] alu_a;
    logic [COEF_W-1:0] alu_b;
    logic [COEF_W-1:0] alu_y;
    logic [AW-1:0]     sat_degree;

    for (genvar g = 0; g < NUM_RAMS; g++)
    begin : g_ram
        ccg_ram #(
            .WIDTH(COEF_W),
            .DEPTH(POLY_DEPTH)
        ) u_ram (
            .clk     (clk),
            .we      (ram_we[g]),
            .wr_addr (ram_waddr[g]),
            .wr_data (ram_wdata[g]),
            .re      (ram_re[g]),
            .rd_addr (ram_raddr[g]),
            .rd_data (ram_rdata[g])
        );
    end

    ccg_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        if (req.degree == '0)
        begin
            sat_degree = AW'(1);
        end
        else if (req.degree > DEG_W'(MAX_DEGREE))
        begin
            sat_degree = AW'(MAX_DEGREE);
        end
        else
        begin
            sat_degree = req.degree[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            old_role_reg   <= role_t'(0);
            cur_role_reg   <= role_t'(1);
            nxt_role_reg   <= role_t'(2);
            n_reg          <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            old_role_reg   <= old_role_next;
            cur_role_reg   <= cur_role_next;
            nxt_role_reg   <= nxt_role_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            j_reg          <= j_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jd_reg       <= jd_next;
        cur_zero_reg <= cur_zero_next;
        old_zero_reg <= old_zero_next;
        second_reg   <= second_next;
        magn_reg     <= magn_next;
        out_reg      <= out_next;
    end

    // shared unit operands: recurrence by default, pass or negate on emit
    always_comb
    begin
        alu_op = ALU_RECUR;
        alu_a  = cur_zero_reg ? '0 : ram_rdata[cur_role_reg];
        alu_b  = old_zero_reg ? '0 : ram_rdata[old_role_reg];
        if (state_reg == ST_EMIT_LD)
        begin
            alu_a  = ram_rdata[cur_role_reg];
            alu_b  = '0;
            alu_op = (magn_reg && ram_rdata[cur_role_reg][COEF_W-1]) ?
                     ALU_NEG : ALU_PASS;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        old_role_next   = old_role_reg;
        cur_role_next   = cur_role_reg;
        nxt_role_next   = nxt_role_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        jd_next         = jd_reg;
        pipe_valid_next = 1'b0;
        cur_zero_next   = cur_zero_reg;
        old_zero_next   = old_zero_reg;
        second_next     = second_reg;
        magn_next       = magn_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        for (int r = 0; r < NUM_RAMS; r++)
        begin
            ram_we[r]    = 1'b0;
            ram_waddr[r] = '0;
            ram_wdata[r] = '0;
            ram_re[r]    = 1'b0;
            ram_raddr[r] = '0;
        end

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        // recurrence write-back, in the cycle after the read
        if (pipe_valid_reg)
        begin
            ram_we[nxt_role_reg]    = 1'b1;
            ram_waddr[nxt_role_reg] = jd_reg;
            ram_wdata[nxt_role_reg] = alu_y;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next        = sat_degree;
                    second_next   = req.second_kind;
                    magn_next     = req.absolute_values;
                    old_role_next = role_t'(0);
                    cur_role_next = role_t'(1);
                    nxt_role_next = role_t'(2);
                    state_next    = ST_INIT0;
                end
            end
            ST_INIT0:
            begin
                ram_we[old_role_reg]    = 1'b1;
                ram_waddr[old_role_reg] = '0;
                ram_wdata[old_role_reg] = COEF_W'(1);
                ram_we[cur_role_reg]    = 1'b1;
                ram_waddr[cur_role_reg] = '0;
                ram_wdata[cur_role_reg] = '0;
                state_next              = ST_INIT1;
            end
            ST_INIT1:
            begin
                ram_we[cur_role_reg]    = 1'b1;
                ram_waddr[cur_role_reg] = AW'(1);
                ram_wdata[cur_role_reg] = second_reg ? COEF_W'(2) : COEF_W'(1);
                j_next                  = '0;
                k_next                  = AW'(1);
                state_next              = (n_reg == AW'(1)) ? ST_EMIT_RD : ST_STEP;
            end
            ST_STEP:
            begin
                // next[j] = 2 cur[j-1] - old[j]; cur[-1] and old[j >= k] are zero
                ram_re[cur_role_reg]    = 1'b1;
                ram_raddr[cur_role_reg] = (j_reg == '0) ? '0 : j_reg - AW'(1);
                ram_re[old_role_reg]    = 1'b1;
                ram_raddr[old_role_reg] = j_reg;
                pipe_valid_next         = 1'b1;
                jd_next                 = j_reg;
                cur_zero_next           = (j_reg == '0);
                old_zero_next           = (j_reg >= k_reg);
                j_next                  = j_reg + AW'(1);
                if (j_reg == k_reg + AW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                old_role_next = cur_role_reg;
                cur_role_next = nxt_role_reg;
                nxt_role_next = old_role_reg;
                j_next        = '0;
                if (k_reg == n_reg - AW'(1))
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_STEP;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re[cur_role_reg]    = 1'b1;
                ram_raddr[cur_role_reg] = j_reg;
                state_next              = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_next.power_index    = DEG_W'(j_reg);
                    out_next.coefficient    = alu_y;
                    out_next.last           = (j_reg == n_reg);
                    j_next                  = j_reg + AW'(1);
                    state_next              = (j_reg == n_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ccg_checker.sv =====
module ccg_checker import ccg_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

    // an accepted request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted while not going busy");

    // degree is at least one, so the last result is never power zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> rsp.power_index != '0)
    else $error("last result at power zero");

    // while a non-final result waits, the run is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> req_stall)
    else $error("idle with a run unfinished");

endmodule

bind chebyshev_coefficient_generator ccg_checker u_ccg_checker (.*);
